>>> rtl/krt_pkg.sv
// krt_pkg: types, codes and helpers shared by the keyed record table.
// No dependencies.
`default_nettype none
package krt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int NAME_CHARS   = 8;
  localparam int CNT_W        = 7;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd16;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_DELETE     = 3'd1;
  localparam logic [2:0] OP_FIND       = 3'd2;
  localparam logic [2:0] OP_SORT_KEY   = 3'd3;
  localparam logic [2:0] OP_SORT_GROUP = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_ITEM = 2'd1;
  localparam logic [1:0] SEL_HOLD = 2'd2;
  localparam logic [1:0] SEL_RAM  = 2'd3;

  localparam logic [1:0] W_ITEM  = 2'd0;
  localparam logic [1:0] W_RDATA = 2'd1;
  localparam logic [1:0] W_CARRY = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] key;
    logic [9:0]  group;
    logic [7:0]  grade;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      rec_key;
    logic [9:0]       rec_group;
    logic [7:0]       rec_grade;
    logic [CNT_W-1:0] entries;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [9:0]  group;
    logic [7:0]  grade;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic       latch;
    logic       re;
    logic       we;
    logic [1:0] wsel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       hold_load;
    logic       carry_load;
    logic       swap_clr;
    logic       swap_set;
    logic       emit;
    logic [1:0] st;
    logic [1:0] osel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             key_match;
    logic             gt;
    logic             swapped;
    logic             out_free;
  } stat_t;

  // clear every byte from the first zero byte on, and past NAME_CHARS
  function automatic logic [63:0] norm_key(input logic [63:0] k);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (k[63-8*b -: 8] == 8'd0 || b >= NAME_CHARS) stop = 1'b1;
      if (!stop) r[63-8*b -: 8] = k[63-8*b -: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/keyed_record_table_top.sv
// Keyed record table: a compact table of up to CAPACITY records searched by
// key. Insert and the unit operations are handled straight from dispatch; find
// and delete search the entries in order, delete then shifts the later entries
// down, dump reads out every record, and a sort of n records runs up to n
// bubble passes (until one makes no swap). The record RAM has one read port
// and one write port.
// Depends on krt_pkg, krt_ctrl, krt_dpath, krt_ram.
`default_nettype none
module keyed_record_table_top #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire krt_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output krt_pkg::out_t                  out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [krt_pkg::CNT_W-1:0] cfg_data
);
  import krt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] raddr, waddr;

  krt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd), .raddr(raddr), .waddr(waddr)
  );

  krt_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .raddr(raddr), .waddr(waddr),
    .stat(stat), .in_data(in_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

>>> rtl/krt_ram.sv
// krt_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/krt_dpath.sv
// krt_dpath: record RAM, entry count, limit register, item latch, compare
// and output register. Depends on krt_pkg and krt_ram.
`default_nettype none
module krt_dpath #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire krt_pkg::cmd_t           cmd,
  input  wire logic [AW-1:0]           raddr,
  input  wire logic [AW-1:0]           waddr,
  output krt_pkg::stat_t               stat,
  input  wire krt_pkg::in_t            in_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [krt_pkg::CNT_W-1:0] cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output krt_pkg::out_t                out_data
);
  import krt_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  in_t              item;
  rec_t             hold, carry, rdata, wrec;
  logic [REC_W-1:0] rdata_raw;
  logic [CNT_W-1:0] count, limit, lim;
  logic             swapped;
  rec_t             osrc;

  assign cfg_ready = 1'b1;
  assign rdata     = rec_t'(rdata_raw);
  assign lim       = (limit > CAP) ? CAP : limit;

  always_comb begin
    case (cmd.wsel)
      W_ITEM:  wrec = '{key: item.key, group: item.group, grade: item.grade};
      W_RDATA: wrec = rdata;
      default: wrec = carry;
    endcase
  end

  krt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (REC_W'(wrec)),
    .re    (cmd.re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_comb begin
    stat.op        = item.operation;
    stat.count     = count;
    stat.full      = count >= lim;
    stat.key_match = rdata.key == item.key;
    if (item.operation == OP_SORT_GROUP && carry.group != rdata.group)
      stat.gt = carry.group > rdata.group;
    else
      stat.gt = carry.key > rdata.key;
    stat.swapped   = swapped;
    stat.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.osel)
      SEL_ITEM: osrc = '{key: item.key, group: item.group, grade: item.grade};
      SEL_HOLD: osrc = hold;
      SEL_RAM:  osrc = rdata;
      default:  osrc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      limit     <= LIMIT_RESET;
      swapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) limit <= cfg_data;
      if (cmd.cnt_inc) count <= count + 1'b1;
      else if (cmd.cnt_dec) count <= count - 1'b1;
      if (cmd.swap_clr) swapped <= 1'b0;
      else if (cmd.swap_set) swapped <= 1'b1;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (cmd.latch) begin
      item.operation <= in_data.operation;
      item.key       <= norm_key(in_data.key);
      item.group     <= in_data.group;
      item.grade     <= in_data.grade;
    end
    if (cmd.hold_load) hold <= rdata;
    if (cmd.carry_load) carry <= rdata;
    if (cmd.emit) begin
      out_data.status    <= cmd.st;
      out_data.rec_key   <= osrc.key;
      out_data.rec_group <= osrc.group;
      out_data.rec_grade <= osrc.grade;
      out_data.entries   <= cmd.cnt_dec ? count - 1'b1 : count;
      out_data.last      <= cmd.last;
    end
  end

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) || count == $past(count) + 1'b1
         || count == $past(count) - 1'b1))
    else $error("entry count jumped");
  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("insert into full table");
`endif
endmodule
`default_nettype wire

>>> rtl/krt_ctrl.sv
// krt_ctrl: sequencer for insert, search, shift, dump and bubble sort.
// Depends on krt_pkg.
`default_nettype none
module krt_ctrl #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire krt_pkg::stat_t stat,
  output krt_pkg::cmd_t       cmd,
  output logic [AW-1:0]       raddr,
  output logic [AW-1:0]       waddr
);
  import krt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH_RD, S_SRCH_CHK, S_SH_RD, S_SH_WR, S_DP_RD, S_DP_OUT,
    S_SR_RD0, S_SR_LD0, S_SR_RD, S_SR_CMP, S_SR_END, S_EMIT
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next, ip1, im1, cm1;
  logic [1:0]       res_st, res_st_next, res_sel, res_sel_next;

  assign ip1 = idx + 1'b1;
  assign im1 = idx - 1'b1;
  assign cm1 = stat.count - 1'b1;
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd          = '0;
    raddr        = idx[AW-1:0];
    waddr        = idx[AW-1:0];
    state_next   = state;
    idx_next     = idx;
    res_st_next  = res_st;
    res_sel_next = res_sel;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.latch  = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        idx_next     = '0;
        state_next   = S_EMIT;
        res_st_next  = ST_OK;
        res_sel_next = SEL_ZERO;
        case (stat.op)
          OP_INSERT: if (stat.full) begin
            res_st_next = ST_FULL;
          end else begin
            cmd.we       = 1'b1;
            cmd.wsel     = W_ITEM;
            waddr        = stat.count[AW-1:0];
            cmd.cnt_inc  = 1'b1;
            res_sel_next = SEL_ITEM;
          end
          OP_DELETE: if (stat.count == '0) res_st_next = ST_EMPTY;
                     else state_next = S_SRCH_RD;
          OP_FIND: if (stat.count == '0) res_st_next = ST_MISSING;
                   else state_next = S_SRCH_RD;
          OP_SORT_KEY, OP_SORT_GROUP: if (stat.count > CNT_W'(1)) state_next = S_SR_RD0;
          OP_DUMP: if (stat.count == '0) res_st_next = ST_EMPTY;
                   else state_next = S_DP_RD;
          default: ;
        endcase
      end
      S_SRCH_RD: begin
        cmd.re     = 1'b1;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (stat.key_match) begin
          cmd.hold_load = 1'b1;
          if (stat.op == OP_FIND) begin
            res_st_next  = ST_OK;
            res_sel_next = SEL_HOLD;
            state_next   = S_EMIT;
          end else begin
            state_next = S_SH_RD;
          end
        end else if (ip1 == stat.count) begin
          res_st_next  = ST_MISSING;
          res_sel_next = SEL_ZERO;
          state_next   = S_EMIT;
        end else begin
          idx_next   = ip1;
          state_next = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        if (ip1 < stat.count) begin
          cmd.re     = 1'b1;
          raddr      = ip1[AW-1:0];
          state_next = S_SH_WR;
        end else if (stat.out_free) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit    = 1'b1;
          cmd.st      = ST_OK;
          cmd.osel    = SEL_HOLD;
          cmd.last    = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SH_WR: begin
        cmd.we     = 1'b1;
        cmd.wsel   = W_RDATA;
        idx_next   = ip1;
        state_next = S_SH_RD;
      end
      S_DP_RD: begin
        cmd.re     = 1'b1;
        state_next = S_DP_OUT;
      end
      S_DP_OUT: if (stat.out_free) begin
        cmd.emit = 1'b1;
        cmd.st   = ST_OK;
        cmd.osel = SEL_RAM;
        cmd.last = ip1 == stat.count;
        idx_next = ip1;
        state_next = cmd.last ? S_IDLE : S_DP_RD;
      end
      S_SR_RD0: begin
        cmd.re       = 1'b1;
        raddr        = '0;
        cmd.swap_clr = 1'b1;
        idx_next     = CNT_W'(1);
        state_next   = S_SR_LD0;
      end
      S_SR_LD0: begin
        cmd.carry_load = 1'b1;
        state_next     = S_SR_RD;
      end
      S_SR_RD: begin
        cmd.re     = 1'b1;
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        cmd.we = 1'b1;
        waddr  = im1[AW-1:0];
        if (stat.gt) begin
          cmd.wsel     = W_RDATA;
          cmd.swap_set = 1'b1;
        end else begin
          cmd.wsel       = W_CARRY;
          cmd.carry_load = 1'b1;
        end
        if (ip1 == stat.count) begin
          state_next = S_SR_END;
        end else begin
          idx_next   = ip1;
          state_next = S_SR_RD;
        end
      end
      S_SR_END: begin
        cmd.we   = 1'b1;
        cmd.wsel = W_CARRY;
        waddr    = cm1[AW-1:0];
        if (stat.swapped) begin
          state_next = S_SR_RD0;
        end else begin
          res_st_next  = ST_OK;
          res_sel_next = SEL_ZERO;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: if (stat.out_free) begin
        cmd.emit   = 1'b1;
        cmd.st     = res_st;
        cmd.osel   = res_sel;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      res_st  <= ST_OK;
      res_sel <= SEL_ZERO;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      res_st  <= res_st_next;
      res_sel <= res_sel_next;
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DISP && state != S_EMIT) |-> idx < stat.count)
    else $error("index past entries");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.we && cmd.re) |-> raddr != waddr)
    else $error("read and write at one address");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result overwrites pending transfer");
`endif
endmodule
`default_nettype wire

>>> tb/sv/tb_keyed_record_table_top.sv
// Testbench for keyed_record_table_top: directed and random operations on the
// record table, each result checked against a behavioural table model.
// Depends on krt_pkg and the keyed_record_table_top RTL.
`default_nettype none
module tb_keyed_record_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  keyed_record_table_top #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // table model
  rec_t tbl[CAP];
  int unsigned held;
  logic [CNT_W-1:0] limit_reg;
  out_t want_q[$];
  int errors;
  bit quiet;      // no idling in the last part
  bit sink_idle;

  function automatic logic [63:0] clean_key(logic [63:0] k);
    logic [63:0] r;
    bit stop;
    r = '0;
    stop = 0;
    for (int b = 0; b < 8; b++) begin
      if (k[63-8*b -: 8] == 8'd0) stop = 1;
      if (!stop) r[63-8*b -: 8] = k[63-8*b -: 8];
    end
    return r;
  endfunction

  function automatic out_t mk(logic [1:0] st, rec_t r, bit lst);
    out_t o;
    o.status = st;
    o.rec_key = r.key;
    o.rec_group = r.group;
    o.rec_grade = r.grade;
    o.entries = held[CNT_W-1:0];
    o.last = lst;
    return o;
  endfunction

  function automatic bit ahead(rec_t a, rec_t b, bit by_group);
    if (by_group && a.group != b.group) return a.group > b.group;
    return a.key > b.key;
  endfunction

  task automatic predict_table(in_t it);
    rec_t r, z, t;
    int idx, lim, j;
    z = '0;
    r.key = clean_key(it.key);
    r.group = it.group;
    r.grade = it.grade;
    lim = (limit_reg < CAP) ? limit_reg : CAP;
    idx = -1;
    for (int i = 0; i < held; i++)
      if (idx < 0 && tbl[i].key == r.key) idx = i;
    case (it.operation)
      OP_INSERT: begin
        if (held >= lim) want_q.push_back(mk(ST_FULL, z, 1));
        else begin
          tbl[held] = r;
          held++;
          want_q.push_back(mk(ST_OK, r, 1));
        end
      end
      OP_DELETE: begin
        if (held == 0) want_q.push_back(mk(ST_EMPTY, z, 1));
        else if (idx < 0) want_q.push_back(mk(ST_MISSING, z, 1));
        else begin
          t = tbl[idx];
          for (int i = idx; i + 1 < held; i++) tbl[i] = tbl[i+1];
          held--;
          want_q.push_back(mk(ST_OK, t, 1));
        end
      end
      OP_FIND: begin
        if (idx < 0) want_q.push_back(mk(ST_MISSING, z, 1));
        else want_q.push_back(mk(ST_OK, tbl[idx], 1));
      end
      OP_SORT_KEY, OP_SORT_GROUP: begin
        for (int i = 1; i < held; i++) begin
          t = tbl[i];
          j = i;
          while (j > 0 && ahead(tbl[j-1], t, it.operation == OP_SORT_GROUP)) begin
            tbl[j] = tbl[j-1];
            j--;
          end
          tbl[j] = t;
        end
        want_q.push_back(mk(ST_OK, z, 1));
      end
      OP_DUMP: begin
        if (held == 0) want_q.push_back(mk(ST_EMPTY, z, 1));
        else for (int i = 0; i < held; i++)
          want_q.push_back(mk(ST_OK, tbl[i], i + 1 == held));
      end
      default: want_q.push_back(mk(ST_OK, z, 1));
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch %s: got %h want %h", what, got, exp);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_t w;
    if (!rst && out_valid && out_ready) begin
      if (want_q.size() == 0)
        report_mismatch("unexpected transfer", out_data.rec_key, 64'd0);
      else begin
        w = want_q.pop_front();
        if (out_data.status !== w.status)
          report_mismatch("status", 64'(out_data.status), 64'(w.status));
        if (out_data.rec_key !== w.rec_key) report_mismatch("rec_key", out_data.rec_key, w.rec_key);
        if (out_data.rec_group !== w.rec_group)
          report_mismatch("rec_group", 64'(out_data.rec_group), 64'(w.rec_group));
        if (out_data.rec_grade !== w.rec_grade)
          report_mismatch("rec_grade", 64'(out_data.rec_grade), 64'(w.rec_grade));
        if (out_data.entries !== w.entries)
          report_mismatch("entries", 64'(out_data.entries), 64'(w.entries));
        if (out_data.last !== w.last)
          report_mismatch("last", 64'(out_data.last), 64'(w.last));
      end
    end
  end

  // sink back-pressure in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (quiet || sink_idle) out_ready <= 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  task automatic send_op(logic [2:0] op, logic [63:0] k, logic [9:0] g, logic [7:0] d);
    in_t it;
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 19)) @(posedge clk);
    it.operation = op;
    it.key = k;
    it.group = g;
    it.grade = d;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (want_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  function automatic logic [63:0] pick_key(int pool);
    logic [63:0] k;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) k = {$urandom, $urandom};
    else if (sel == 1) k = {8'h41 + 8'($urandom_range(0, pool)), 8'h00, $urandom, 16'($urandom)};
    else k = {8'h41 + 8'($urandom_range(0, pool)), 8'h61 + 8'($urandom_range(0, 1)), 48'h0};
    return k;
  endfunction

  task automatic test_directed();
    send_op(OP_DUMP, 0, 0, 0);
    send_op(OP_DELETE, 64'h4100_0000_0000_0000, 0, 0);
    send_op(OP_FIND, 64'h4100_0000_0000_0000, 0, 0);
    send_op(OP_SORT_KEY, 0, 0, 0);
    send_op(OP_INSERT, '1, 10'h3ff, 8'hff);
    send_op(OP_INSERT, '0, 0, 0);
    send_op(OP_INSERT, 64'h4200_ffff_0000_0000, 10'd5, 8'd7);
    send_op(OP_INSERT, 64'h4100_0000_0000_0000, 10'd5, 8'd9);
    send_op(OP_INSERT, 64'h4100_0000_0000_0000, 10'd1, 8'd3);
    send_op(OP_FIND, 64'h4200_1234_0000_0000, 0, 0);
    send_op(OP_FIND, 64'h5a00_0000_0000_0000, 0, 0);
    send_op(OP_SORT_GROUP, 0, 0, 0);
    send_op(OP_DUMP, 0, 0, 0);
    send_op(OP_SORT_KEY, 0, 0, 0);
    send_op(OP_DUMP, 0, 0, 0);
    send_op(3'd6, '1, '1, '1);
    send_op(3'd7, 0, 0, 0);
    send_op(OP_DELETE, 64'h4100_0000_0000_0000, 0, 0);
    send_op(OP_DELETE, 64'h5a00_0000_0000_0000, 0, 0);
    send_op(OP_DUMP, 0, 0, 0);
  endtask

  task automatic test_full_limits();
    write_limit(7'd1);
    send_op(OP_INSERT, 64'h4300_0000_0000_0000, 1, 1);
    send_op(OP_INSERT, 64'h4400_0000_0000_0000, 1, 1);
    while (held > 0) send_op(OP_DELETE, tbl[0].key, 0, 0);
    write_limit(7'd0);
    send_op(OP_INSERT, 64'h4300_0000_0000_0000, 1, 1);
    write_limit(7'd127);
    for (int i = 0; i < CAP + 1; i++)
      send_op(OP_INSERT, {$urandom, $urandom}, 10'($urandom), 8'($urandom));
    send_op(OP_SORT_KEY, 0, 0, 0);
    send_op(OP_DUMP, 0, 0, 0);
  endtask

  task automatic test_random(int count, int lim);
    int r;
    logic [2:0] op;
    write_limit(7'(lim));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_INSERT;
      else if (r < 55) op = OP_DELETE;
      else if (r < 72) op = OP_FIND;
      else if (r < 80) op = OP_SORT_KEY;
      else if (r < 88) op = OP_SORT_GROUP;
      else if (r < 96) op = OP_DUMP;
      else op = 3'($urandom_range(6, 7));
      if ((op == OP_DELETE || op == OP_FIND) && held > 0 && $urandom_range(0, 1))
        send_op(op, tbl[$urandom_range(0, held - 1)].key, 10'($urandom), 8'($urandom));
      else
        send_op(op, pick_key(6), 10'($urandom_range(0, 3)) | ($urandom_range(0, 5) == 0 ?
                10'($urandom) : 10'd0), 8'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    held = 0;
    quiet = 0;
    sink_idle = 0;
    limit_reg = LIMIT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_limits();
    test_random(120, 16);
    test_random(80, 5);
    test_random(80, 64);
    quiet = 1;
    test_random(100, 12);
    drain();
    if (errors == 0 && want_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
